@@ hdl/ccd_pkg.sv @@
// Shared types and constants for the cadence crossing detector.
`default_nettype none

package ccd_pkg;

  localparam int SAMPLE_W = 14;
  localparam int TS_W     = 48;
  localparam int SENS_W   = 14;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [TS_W-1:0]     ts_t;
  typedef logic        [SENS_W-1:0]   sens_t;
  typedef logic signed [1:0]          cross_t;

  localparam sens_t  SENS_RESET = sens_t'(100);

  localparam cross_t CROSS_NONE = 2'sb00;
  localparam cross_t CROSS_UP   = 2'sb01;
  localparam cross_t CROSS_DOWN = 2'sb11;

  // Detector verdict for one item, handed to the result register.
  typedef struct packed {
    cross_t crossing;
    logic   cadence_pulse;
    ts_t    last_cadence_time;
  } det_res_t;

endpackage : ccd_pkg

`default_nettype wire

@@ hdl/ccd_in_if.sv @@
// Input channel: one accelerometer sample with its timestamp per item.
`default_nettype none

interface ccd_in_if;
  import ccd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  ts_t     timestamp_us;

  modport source (output valid, output sample, output timestamp_us, input ready);
  modport sink   (input valid, input sample, input timestamp_us, output ready);
endinterface : ccd_in_if

`default_nettype wire

@@ hdl/ccd_out_if.sv @@
// Result channel: crossing verdict, window mean and last cadence time per item.
`default_nettype none

interface ccd_out_if;
  import ccd_pkg::*;

  logic    valid;
  logic    ready;
  cross_t  crossing;
  logic    cadence_pulse;
  sample_t window_mean;
  ts_t     last_cadence_time;

  modport source (output valid, output crossing, output cadence_pulse,
                  output window_mean, output last_cadence_time, input ready);
  modport sink   (input valid, input crossing, input cadence_pulse,
                  input window_mean, input last_cadence_time, output ready);
endinterface : ccd_out_if

`default_nettype wire

@@ hdl/ccd_mean_div.sv @@
// Signed division of the window sum by the window depth, truncating toward zero.
`default_nettype none

module ccd_mean_div #(
  parameter int WINDOW_DEPTH = 8,
  parameter int SUM_W        = 17
) (
  input  wire logic signed [SUM_W-1:0] sum_i,
  output ccd_pkg::sample_t             mean_o
);
  import ccd_pkg::*;

  // Exact floor(n / D) for any n below 2**SUM_W via one multiply and shift.
  localparam int CLOG_D = $clog2(WINDOW_DEPTH);
  localparam int SHIFT  = SUM_W + CLOG_D;
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam int Q_W    = SAMPLE_W + 1;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]   quot;
  logic [Q_W-1:0]   signed_q;

  always_comb begin
    neg      = sum_i[SUM_W-1];
    mag      = neg ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    prod     = {{(SUM_W + 1){1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
    quot     = prod[SHIFT +: Q_W];
    signed_q = neg ? Q_W'(-quot) : quot;
    mean_o   = sample_t'(signed_q[SAMPLE_W-1:0]);
  end

endmodule : ccd_mean_div

`default_nettype wire

@@ hdl/ccd_window.sv @@
// Sample window as a shift line with a running sum, and its mean.
`default_nettype none

module ccd_window #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_i,
  input  wire ccd_pkg::sample_t sample_i,
  output ccd_pkg::sample_t      mean_o
);
  import ccd_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  sample_t                 taps_r [WINDOW_DEPTH];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // Drop the oldest sample as the new one enters.
  always_comb begin
    sum_nxt = sum_r + SUM_W'(sample_i) - SUM_W'(taps_r[WINDOW_DEPTH-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        taps_r[i] <= '0;
      end
    end else if (step_i) begin
      sum_r     <= sum_nxt;
      taps_r[0] <= sample_i;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

  ccd_mean_div #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_div (
    .sum_i  (sum_nxt),
    .mean_o (mean_o)
  );

endmodule : ccd_window

`default_nettype wire

@@ hdl/ccd_detect.sv @@
// Crossing detector with running max/min amplitude gate and cadence time.
`default_nettype none

module ccd_detect (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_i,
  input  wire ccd_pkg::sample_t sample_i,
  input  wire ccd_pkg::ts_t     ts_i,
  input  wire ccd_pkg::sample_t mean_i,
  input  wire ccd_pkg::sens_t   sens_i,
  output ccd_pkg::det_res_t     res_o
);
  import ccd_pkg::*;

  sample_t max_r, max_nxt;
  sample_t min_r, min_nxt;
  sample_t pmean_r;
  sample_t psample_r;
  ts_t     ctime_r, ctime_nxt;

  sample_t               mx1;
  sample_t               mn1;
  logic signed [SAMPLE_W:0] span;
  logic                  up;
  logic                  dn;
  logic                  too_small;
  logic                  up_fire;
  logic                  dn_fire;

  always_comb begin
    mx1       = (sample_i > max_r) ? sample_i : max_r;
    mn1       = (sample_i < min_r) ? sample_i : min_r;
    span      = {mx1[SAMPLE_W-1], mx1} - {mn1[SAMPLE_W-1], mn1};
    too_small = span < $signed({1'b0, sens_i});
    up        = (pmean_r < psample_r) && (mean_i >= sample_i);
    dn        = (pmean_r >= psample_r) && (mean_i < sample_i);
    up_fire   = up && !too_small;
    dn_fire   = dn && !too_small;
    max_nxt   = up_fire ? sample_i : mx1;
    min_nxt   = dn_fire ? sample_i : mn1;
    ctime_nxt = up_fire ? ts_i : ctime_r;
  end

  always_comb begin
    res_o.crossing          = up_fire ? CROSS_UP : (dn_fire ? CROSS_DOWN : CROSS_NONE);
    res_o.cadence_pulse     = up_fire;
    res_o.last_cadence_time = ctime_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      min_r     <= '0;
      pmean_r   <= '0;
      psample_r <= '0;
      ctime_r   <= '0;
    end else if (step_i) begin
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      pmean_r   <= mean_i;
      psample_r <= sample_i;
      ctime_r   <= ctime_nxt;
    end
  end

endmodule : ccd_detect

`default_nettype wire

@@ hdl/cadence_crossing_detector.sv @@
// Top level of the cadence crossing detector: handshake stages and configuration.
// Takes one item per clock cycle without bubbles while out_if.ready is high. An
// accepted item sits in the input register, where the window sum, the mean (a
// multiply by the reciprocal of WINDOW_DEPTH) and the crossing decision are
// worked out and the state updated, and its result is then registered in the
// output register. The output register holds while out_if.ready is low, and the
// input stage still takes one more item if it is empty.
// Reset clears the valid flags, the sample window and the detector state and
// loads SENS_RESET into the sensitivity; the data registers are not reset.
`default_nettype none

module cadence_crossing_detector #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  ccd_in_if.sink              in_if,
  ccd_out_if.source           out_if,
  input  wire logic           cfg_we,
  input  wire ccd_pkg::sens_t cfg_wdata
);
  import ccd_pkg::*;

  sens_t    sens_r;
  logic     s1_v_r, s1_v_nxt;
  sample_t  s1_sample_r;
  ts_t      s1_ts_r;
  logic     out_v_r;
  det_res_t out_res_r;
  sample_t  out_mean_r;

  logic     adv;
  logic     step;
  logic     in_fire;
  sample_t  mean;
  det_res_t res;

  always_comb begin
    adv         = !out_v_r || out_if.ready;
    step        = s1_v_r && adv;
    in_if.ready = !s1_v_r || adv;
    in_fire     = in_if.valid && in_if.ready;
    s1_v_nxt    = in_fire || (s1_v_r && !step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= SENS_RESET;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sens_r <= cfg_wdata;
      end
      s1_v_r <= s1_v_nxt;
      if (adv) begin
        out_v_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_if.sample;
      s1_ts_r     <= in_if.timestamp_us;
    end
    if (step) begin
      out_res_r  <= res;
      out_mean_r <= mean;
    end
  end

  ccd_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .sample_i (s1_sample_r),
    .mean_o   (mean)
  );

  ccd_detect u_detect (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .sample_i (s1_sample_r),
    .ts_i     (s1_ts_r),
    .mean_i   (mean),
    .sens_i   (sens_r),
    .res_o    (res)
  );

  always_comb begin
    out_if.valid             = out_v_r;
    out_if.crossing          = out_res_r.crossing;
    out_if.cadence_pulse     = out_res_r.cadence_pulse;
    out_if.window_mean       = out_mean_r;
    out_if.last_cadence_time = out_res_r.last_cadence_time;
  end

  // Pulse and upward crossing must agree on every delivered result.
  a_pulse_matches_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.cadence_pulse == (out_if.crossing == CROSS_UP)))
    else $error("cadence pulse disagrees with crossing");

  // Never accept into a full input stage that is not advancing.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_v_r || step))
    else $error("input stage overrun");

  // A finished step always lands in the result register.
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("result lost after step");

  // An upward crossing records the timestamp of its own item.
  a_up_records_time: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.crossing == CROSS_UP) |=>
      (out_if.last_cadence_time == $past(s1_ts_r)))
    else $error("cadence time not recorded");

endmodule : cadence_crossing_detector

`default_nettype wire
